### sv/gf2_polynomial_mul_div_top_assert.svh
// assertion macros used by the gf2 polynomial mul/div sequencer
`ifndef GF2_POLYNOMIAL_MUL_DIV_TOP_ASSERT_SVH
`define GF2_POLYNOMIAL_MUL_DIV_TOP_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define GF2PM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define GF2PM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gf2pm_pkg.sv
// shared types, command codes and widths of the gf2 polynomial mul/div unit
package gf2pm_pkg;

    localparam int unsigned WIDTH  = 32;  // operand bits taken into account, 2..32
    localparam int unsigned OPND_W = 32;
    localparam int unsigned PQ_W   = 63;
    localparam int unsigned REM_W  = 32;
    localparam int unsigned CNT_W  = $clog2(WIDTH);

    typedef logic [PQ_W-1:0]  t_pq;
    typedef logic [REM_W-1:0] t_rem;
    typedef logic [WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0] t_cnt;

    // commands broadcast to every cell of the row
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_HOLD = 3'd0;
    localparam t_cmd CMD_LOAD = 3'd1;
    localparam t_cmd CMD_MUL  = 3'd2;
    localparam t_cmd CMD_NORM = 3'd3;
    localparam t_cmd CMD_DIV  = 3'd4;
    localparam t_cmd CMD_UNSH = 3'd5;

    typedef struct packed {
        t_cmd cmd;
        logic step_bit;  // multiplier lsb when multiplying, remainder msb when dividing
    } t_ctl;

    // one bit position of the datapath
    typedef struct packed {
        logic a;  // multiplicand
        logic b;  // multiplier or divisor
        logic r;  // upper product half or remainder
        logic q;  // lower product half or quotient
    } t_bits;

    typedef struct packed {
        logic b_lsb;
        logic b_msb;
        logic r_msb;
    } t_stat;

    typedef struct packed {
        logic cap;  // take the row contents into the output register
        logic mul;
        logic dz;
    } t_done;

endpackage

### sv/gf2pm_cell.sv
// one bit cell of the gf2 mul/div row
module gf2pm_cell (
    input  logic             i_clk,
    input  gf2pm_pkg::t_ctl  i_ctl,
    input  gf2pm_pkg::t_bits i_ld,
    input  gf2pm_pkg::t_bits i_up,
    input  gf2pm_pkg::t_bits i_dn,
    output gf2pm_pkg::t_bits o_bits
);

    gf2pm_pkg::t_bits r_bits;
    gf2pm_pkg::t_bits n_bits;

    always_comb begin
        n_bits = r_bits;
        unique case (i_ctl.cmd)
            gf2pm_pkg::CMD_HOLD: begin
                n_bits = r_bits;
            end
            gf2pm_pkg::CMD_LOAD: begin
                n_bits.a = i_ld.a;
                n_bits.b = i_ld.b;
                n_bits.r = i_ld.r;
                n_bits.q = 1'b0;
            end
            gf2pm_pkg::CMD_MUL: begin
                // add multiplicand when selected, shift down one place
                n_bits.r = i_up.r ^ (i_ctl.step_bit & i_up.a);
                n_bits.q = i_up.q;
                n_bits.b = i_up.b;
            end
            gf2pm_pkg::CMD_NORM: begin
                n_bits.b = i_dn.b;
            end
            gf2pm_pkg::CMD_DIV: begin
                // subtract aligned divisor when top bit set, shift up one place
                n_bits.r = i_dn.r ^ (i_ctl.step_bit & i_dn.b);
                n_bits.q = i_dn.q;
            end
            gf2pm_pkg::CMD_UNSH: begin
                n_bits.r = i_up.r;
            end
            default: begin
                n_bits = r_bits;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_bits = r_bits;

endmodule

### sv/gf2pm_seq.sv
// sequencer that steps the cell row through multiply or long division
module gf2pm_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  logic             i_b_zero,
    input  gf2pm_pkg::t_stat i_stat,
    input  logic             i_out_free,
    output logic             o_in_ready,
    output gf2pm_pkg::t_ctl  o_ctl,
    output gf2pm_pkg::t_done o_done
);

    `include "gf2_polynomial_mul_div_top_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_NORM = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_UNSH = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam gf2pm_pkg::t_cnt K_LAST = gf2pm_pkg::t_cnt'(gf2pm_pkg::WIDTH - 1);

    logic [2:0]      r_state, n_state;
    gf2pm_pkg::t_cnt r_s, n_s;  // divisor alignment shift
    gf2pm_pkg::t_cnt r_k, n_k;  // step count in the current phase
    logic            r_func, n_func;
    logic            r_dz, n_dz;

    always_comb begin
        n_state       = r_state;
        n_s           = r_s;
        n_k           = r_k;
        n_func        = r_func;
        n_dz          = r_dz;
        o_ctl.cmd     = gf2pm_pkg::CMD_HOLD;
        o_ctl.step_bit = (r_state == ST_MUL) ? i_stat.b_lsb : i_stat.r_msb;
        o_done.cap    = 1'b0;
        o_done.mul    = ~r_func;
        o_done.dz     = r_dz;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = gf2pm_pkg::CMD_LOAD;
                    n_func    = i_func;
                    n_dz      = i_func & i_b_zero;
                    n_s       = '0;
                    n_k       = '0;
                    priority if (!i_func) begin
                        n_state = ST_MUL;
                    end else if (i_b_zero) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_NORM;
                    end
                end
            end
            ST_MUL: begin
                o_ctl.cmd = gf2pm_pkg::CMD_MUL;
                if (r_k == K_LAST) begin
                    n_state = ST_FIN;
                end else begin
                    n_k = r_k + gf2pm_pkg::t_cnt'(1);
                end
            end
            ST_NORM: begin
                if (i_stat.b_msb) begin
                    n_state = ST_DIV;
                end else begin
                    o_ctl.cmd = gf2pm_pkg::CMD_NORM;
                    n_s       = r_s + gf2pm_pkg::t_cnt'(1);
                end
            end
            ST_DIV: begin
                o_ctl.cmd = gf2pm_pkg::CMD_DIV;
                if (r_k == r_s) begin
                    n_state = ST_UNSH;
                    n_k     = '0;
                end else begin
                    n_k = r_k + gf2pm_pkg::t_cnt'(1);
                end
            end
            ST_UNSH: begin
                o_ctl.cmd = gf2pm_pkg::CMD_UNSH;
                if (r_k == r_s) begin
                    n_state = ST_FIN;
                end else begin
                    n_k = r_k + gf2pm_pkg::t_cnt'(1);
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_done.cap = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s     <= '0;
            r_k     <= '0;
            r_func  <= 1'b0;
            r_dz    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_k     <= n_k;
            r_func  <= n_func;
            r_dz    <= n_dz;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    `GF2PM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "block still ready after taking a word")
    `GF2PM_ASSERT_NOW(a_divisor_aligned, r_state == ST_DIV, i_stat.b_msb,
        "divisor not aligned during division")
    `GF2PM_ASSERT_NOW(a_step_in_range, r_state == ST_DIV || r_state == ST_UNSH, r_k <= r_s,
        "division step count passed the alignment shift")
    `GF2PM_ASSERT_NEXT(a_idle_after_capture, o_done.cap, o_in_ready,
        "sequencer not idle after result capture")

endmodule

### sv/gf2_polynomial_mul_div_top.sv
// top level of the gf2 polynomial multiply and long division unit
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_func, i_operand_a, i_operand_b
//  out     | output    | o_out_valid / i_out_ready | o_product_or_quotient, o_remainder,
//          |           |                           | o_divide_by_zero
//
//  one word is worked at a time in a row of WIDTH bit cells, each cell talking to its two
//  neighbors and the top cell also to bit 0; the row shifts at most once per cycle.
//  multiply: one shift-and-add step per multiplier bit; a new word is taken only when
//  the sequencer is back in idle after the result capture.
//  divide: with s = WIDTH-1-deg(divisor): the divisor is shifted up until aligned,
//  s+1 division steps follow, then the remainder is shifted back down s+1 places;
//  a zero divisor skips straight to the result.
//  the output register lets the next word enter while a result still waits; the row
//  then holds its finished result until the output register frees up.
//  reset is synchronous, active low, and clears control only.
module gf2_polynomial_mul_div_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [62:0] o_product_or_quotient,
    output logic [31:0] o_remainder,
    output logic        o_divide_by_zero
);

    localparam int unsigned W = gf2pm_pkg::WIDTH;

    gf2pm_pkg::t_ctl  w_ctl;
    gf2pm_pkg::t_stat w_stat;
    gf2pm_pkg::t_done w_done;
    gf2pm_pkg::t_bits w_bits [W];
    gf2pm_pkg::t_bits w_ld   [W];
    gf2pm_pkg::t_bits w_up   [W];
    gf2pm_pkg::t_bits w_dn   [W];
    gf2pm_pkg::t_word w_r;
    gf2pm_pkg::t_word w_q;
    logic             w_b_zero;
    logic             w_out_free;

    logic             r_out_valid;
    gf2pm_pkg::t_pq   r_pq;
    gf2pm_pkg::t_rem  r_rem;
    logic             r_dz;

    // operand bits at and above WIDTH play no part
    assign w_b_zero   = (i_operand_b[W-1:0] == '0);
    assign w_out_free = !r_out_valid || i_out_ready;

    gf2pm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_b_zero   (w_b_zero),
        .i_stat     (w_stat),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl),
        .o_done     (w_done)
    );

    // cell row, bit 0 at the bottom
    for (genvar i = 0; i < W; i++) begin : g_cell
        // multiply starts with a clear upper half, divide with the dividend as remainder
        assign w_ld[i].a = i_operand_a[i];
        assign w_ld[i].b = i_operand_b[i];
        assign w_ld[i].r = i_func & i_operand_a[i];
        assign w_ld[i].q = 1'b0;

        if (i == W - 1) begin : g_top
            // bit leaving the upper half feeds the lower product half
            assign w_up[i].a = 1'b0;
            assign w_up[i].b = 1'b0;
            assign w_up[i].r = 1'b0;
            assign w_up[i].q = w_bits[0].r ^ (w_ctl.step_bit & w_bits[0].a);
        end else begin : g_mid_up
            assign w_up[i] = w_bits[i+1];
        end

        if (i == 0) begin : g_bot
            // new quotient bit enters at the bottom
            assign w_dn[i].a = 1'b0;
            assign w_dn[i].b = 1'b0;
            assign w_dn[i].r = 1'b0;
            assign w_dn[i].q = w_ctl.step_bit;
        end else begin : g_mid_dn
            assign w_dn[i] = w_bits[i-1];
        end

        gf2pm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_ld   (w_ld[i]),
            .i_up   (w_up[i]),
            .i_dn   (w_dn[i]),
            .o_bits (w_bits[i])
        );

        assign w_r[i] = w_bits[i].r;
        assign w_q[i] = w_bits[i].q;
    end

    assign w_stat.b_lsb = w_bits[0].b;
    assign w_stat.b_msb = w_bits[W-1].b;
    assign w_stat.r_msb = w_bits[W-1].r;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done.cap) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done.cap) begin
            if (w_done.mul) begin
                // product top bit is always clear, drop it
                r_pq  <= gf2pm_pkg::t_pq'({w_r[W-2:0], w_q});
                r_rem <= '0;
            end else begin
                r_pq  <= gf2pm_pkg::t_pq'(w_q);
                r_rem <= gf2pm_pkg::t_rem'(w_r);
            end
            r_dz <= w_done.dz;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_product_or_quotient = r_pq;
    assign o_remainder           = r_rem;
    assign o_divide_by_zero      = r_dz;

endmodule
